FILE: sv/palette_bitplane_tile_encoder_defines.svh
// Assertion macros shared by the encoder modules.
`ifndef PALETTE_BITPLANE_TILE_ENCODER_DEFINES_SVH
`define PALETTE_BITPLANE_TILE_ENCODER_DEFINES_SVH

// Checked only outside reset.
`define PBTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define PBTE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pbte_pkg.sv
package pbte_pkg;

	// tile geometry, each in 1..8
	localparam int TILE_COLUMNS = 8;
	localparam int TILE_ROWS    = 8;

	localparam logic [2:0] X_LAST = 3'(TILE_COLUMNS - 1);
	localparam logic [2:0] Y_LAST = 3'(TILE_ROWS - 1);

	localparam int PAL_ENTRIES = 4;
	localparam int JOB_BYTES   = 16;

	// job queue, depth a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_PIXEL  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [3:0] BYTE_LAST = 4'(JOB_BYTES - 1);

	typedef enum logic [1:0] {
		JOB_TILE    = 2'd0,
		JOB_PALETTE = 2'd1,
		JOB_ERROR   = 2'd2
	} job_kind_t;

	// one output burst: byte 0 goes out first
	typedef struct packed {
		job_kind_t                   kind;
		logic [JOB_BYTES-1:0][7:0]   bytes;
	} job_t;

	// queue status seen by the input stall and the back end
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage

FILE: sv/palette_bitplane_tile_encoder.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    opcode, red, green, blue, alpha
// out      out_valid / out_stall  data_byte, kind, status, last
//
// One input beat per cycle while in_stall is low; palette match and plane update finish in that cycle.
// A completed tile or a finish becomes a job in a two-entry queue; the back end
// sends 16 bytes per job (one for an error finish), one byte per cycle while out_stall is low.
// in_stall rises only while the queue holds two jobs the back end has not started.
// Reset is asynchronous, active low, and clears counters, planes and flags.
module palette_bitplane_tile_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       kind,
	output logic       status,
	output logic       last
);
	import pbte_pkg::*;

	logic    accept;
	logic    push;
	logic    pop;
	job_t    push_job;
	job_t    head_job;
	q_stat_t qstat;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	pbte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.opcode (opcode),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.alpha  (alpha),
		.push   (push),
		.job    (push_job)
	);

	pbte_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (qstat)
	);

	pbte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.stat      (qstat),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.data_byte (data_byte),
		.kind      (kind),
		.status    (status),
		.last      (last)
	);

endmodule

FILE: sv/pbte_front.sv
module pbte_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           opcode,
	input  logic [7:0]     red,
	input  logic [7:0]     green,
	input  logic [7:0]     blue,
	input  logic [7:0]     alpha,
	output logic           push,
	output pbte_pkg::job_t job
);
	import pbte_pkg::*;

	logic [31:0] pal_q [PAL_ENTRIES];
	logic [2:0]  count_q;
	logic        overflow_q;
	logic [2:0]  x_q;
	logic [2:0]  y_q;
	logic [7:0]  plane_lo_q [8];
	logic [7:0]  plane_hi_q [8];

	logic [31:0] color;
	logic        hit;
	logic [1:0]  hit_idx;
	logic [1:0]  idx;
	logic        pix;
	logic        ovf_set;
	logic        pix_ok;
	logic        tile_done;
	logic        fin;
	logic [2:0]  row;
	logic [7:0]  lo_n [8];
	logic [7:0]  hi_n [8];

	assign color = {red, green, blue, alpha};

	// four-way palette compare, first stored match wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = 2'd0;
		for (int i = 0; i < PAL_ENTRIES; i++) begin
			if (!hit && (3'(i) < count_q) && (pal_q[i] == color)) begin
				hit     = 1'b1;
				hit_idx = 2'(i);
			end
		end
	end

	// classify the beat
	assign pix       = accept && (opcode == OP_PIXEL) && !overflow_q;
	assign ovf_set   = pix && !hit && count_q[2];
	assign pix_ok    = pix && !ovf_set;
	assign idx       = hit ? hit_idx : count_q[1:0];
	assign tile_done = pix_ok && (x_q == X_LAST) && (y_q == Y_LAST);
	assign fin       = accept && (opcode == OP_FINISH);
	assign row       = Y_LAST - y_q;

	// planes with the current pixel merged in
	always_comb begin
		for (int r = 0; r < 8; r++) begin
			lo_n[r] = plane_lo_q[r];
			hi_n[r] = plane_hi_q[r];
		end
		lo_n[row][x_q] = plane_lo_q[row][x_q] | idx[0];
		hi_n[row][x_q] = plane_hi_q[row][x_q] | idx[1];
	end

	// job toward the back end
	assign push = tile_done || fin;
	always_comb begin
		job.bytes = '0;
		if (fin) begin
			job.kind = overflow_q ? JOB_ERROR : JOB_PALETTE;
			for (int k = 0; k < JOB_BYTES; k++) begin
				job.bytes[k] = pal_q[k / 4][(3 - (k % 4)) * 8 +: 8];
			end
		end else begin
			job.kind = JOB_TILE;
			for (int r = 0; r < 8; r++) begin
				job.bytes[r]     = lo_n[r];
				job.bytes[8 + r] = hi_n[r];
			end
		end
	end

	// palette storage, no reset: entries beyond the count are never matched
	always_ff @(posedge clk) begin
		if (pix_ok && !hit) begin
			pal_q[count_q[1:0]] <= color;
		end
	end

	// sheet and tile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= 3'd0;
			overflow_q <= 1'b0;
			x_q        <= 3'd0;
			y_q        <= 3'd0;
			for (int r = 0; r < 8; r++) begin
				plane_lo_q[r] <= 8'd0;
				plane_hi_q[r] <= 8'd0;
			end
		end else if (fin) begin
			count_q    <= 3'd0;
			overflow_q <= 1'b0;
			x_q        <= 3'd0;
			y_q        <= 3'd0;
			for (int r = 0; r < 8; r++) begin
				plane_lo_q[r] <= 8'd0;
				plane_hi_q[r] <= 8'd0;
			end
		end else if (ovf_set) begin
			overflow_q <= 1'b1;
		end else if (pix_ok) begin
			if (!hit) begin
				count_q <= count_q + 3'd1;
			end
			for (int r = 0; r < 8; r++) begin
				plane_lo_q[r] <= tile_done ? 8'd0 : lo_n[r];
				plane_hi_q[r] <= tile_done ? 8'd0 : hi_n[r];
			end
			if (y_q == Y_LAST) begin
				y_q <= 3'd0;
				x_q <= (x_q == X_LAST) ? 3'd0 : x_q + 3'd1;
			end else begin
				y_q <= y_q + 3'd1;
			end
		end
	end

endmodule

FILE: sv/pbte_queue.sv
`include "palette_bitplane_tile_encoder_defines.svh"

module pbte_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pbte_pkg::job_t    push_job,
	input  logic              pop,
	output pbte_pkg::job_t    head_job,
	output pbte_pkg::q_stat_t stat
);
	import pbte_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_job   = entry_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	// job storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`PBTE_ASSERT(a_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
	`PBTE_ASSERT(a_no_push_full, !(push && stat.full), "push into full queue")
	`PBTE_ASSERT(a_no_pop_empty, !(pop && !stat.valid), "pop from empty queue")
	`PBTE_ASSERT(a_push_grows, (push && !pop) |=> count_q == $past(count_q) + QCNT_W'(1), "count did not grow")

endmodule

FILE: sv/pbte_back.sv
`include "palette_bitplane_tile_encoder_defines.svh"

module pbte_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pbte_pkg::job_t    head_job,
	input  pbte_pkg::q_stat_t stat,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        data_byte,
	output logic              kind,
	output logic              status,
	output logic              last
);
	import pbte_pkg::*;

	job_t       job_q;
	logic       valid_q;
	logic [3:0] idx_q;
	logic       take;
	logic       last_byte;

	assign take      = valid_q && !out_stall;
	assign last_byte = (job_q.kind == JOB_ERROR) || (idx_q == BYTE_LAST);
	assign pop       = stat.valid && (!valid_q || (take && last_byte));

	// output fields come straight from held registers
	assign out_valid = valid_q;
	assign data_byte = (job_q.kind == JOB_ERROR) ? 8'd0 : job_q.bytes[idx_q];
	assign kind      = (job_q.kind != JOB_TILE);
	assign status    = (job_q.kind == JOB_ERROR);
	assign last      = last_byte;

	// current job payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	// burst control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 4'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= 4'd0;
		end else if (take && last_byte) begin
			valid_q <= 1'b0;
			idx_q   <= 4'd0;
		end else if (take) begin
			idx_q   <= idx_q + 4'd1;
		end
	end

	`PBTE_ASSERT(a_idle_idx, valid_q || (idx_q == 4'd0), "byte index moved while idle")
	`PBTE_ASSERT(a_err_single, (idx_q != 4'd0) |-> (job_q.kind == JOB_TILE || job_q.kind == JOB_PALETTE), "error job past one beat")
	`PBTE_ASSERT(a_drain, (take && last_byte && !stat.valid) |=> !valid_q, "valid held after final beat")

endmodule

FILE: dv/testbench.sv
module testbench;
	import pbte_pkg::*;

	// output codes
	localparam logic KIND_PLANE      = 1'b0;
	localparam logic KIND_SHEET      = 1'b1;
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	localparam int WATCHDOG    = 5000;
	localparam int DRAIN       = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_BEATS = 220;

	typedef struct packed {
		logic       op;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pix_beat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic       status;
		logic       last;
	} out_byte_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       opcode    = OP_PIXEL;
	logic [7:0] red       = 8'h00;
	logic [7:0] green     = 8'h00;
	logic [7:0] blue      = 8'h00;
	logic [7:0] alpha     = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] data_byte;
	logic       kind;
	logic       status;
	logic       last;

	palette_bitplane_tile_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_byte (data_byte),
		.kind      (kind),
		.status    (status),
		.last      (last)
	);

	always #2 clk = ~clk;

	wire in_beat  = arst_n && in_valid && !in_stall;
	wire out_beat = arst_n && out_valid && !out_stall;

	pix_beat_t pixel_feed[$];
	out_byte_t expected_bytes[$];

	// encoder shadow state
	logic [31:0] pal_colors [PAL_ENTRIES];
	int          pal_count;
	int          tile_pos;
	logic [7:0]  lo_rows [8];
	logic [7:0]  hi_rows [8];
	bit          spilled;

	int mismatches     = 0;
	int beats_in       = 0;
	int bytes_out      = 0;
	int tiles_done     = 0;
	int palettes_done  = 0;
	int overflow_dumps = 0;
	int quiet          = 0;

	bit        in_taken   = 1'b0;
	int        feed_gap   = 0;
	int        in_burst   = 0;
	int        stall_left = 0;
	int        out_burst  = 0;
	int        hold_left  = 0;
	bit        hold_done  = 1'b0;
	pix_beat_t next_beat;

	function automatic int gap_length(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 6) begin
			burst = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_tile();
		for (int k = 0; k < 8; k++) begin
			lo_rows[k] = 8'h00;
			hi_rows[k] = 8'h00;
		end
		tile_pos = 0;
	endfunction

	function automatic void clear_sheet();
		for (int k = 0; k < PAL_ENTRIES; k++)
			pal_colors[k] = 32'h0;
		pal_count = 0;
		spilled   = 1'b0;
		clear_tile();
	endfunction

	// next expected bytes for one accepted input beat
	function automatic void encode_beat(pix_beat_t bt);
		logic [31:0] color;
		logic [1:0]  idx;
		bit          found;
		int          x;
		int          row;
		out_byte_t   ob;
		if (bt.op == OP_FINISH) begin
			if (spilled) begin
				ob = '{8'h00, KIND_SHEET, STATUS_OVERFLOW, 1'b1};
				expected_bytes.push_back(ob);
				overflow_dumps++;
			end else begin
				for (int k = 0; k < JOB_BYTES; k++) begin
					ob.data   = pal_colors[k / 4][31 - 8 * (k % 4) -: 8];
					ob.kind   = KIND_SHEET;
					ob.status = STATUS_OK;
					ob.last   = (k == JOB_BYTES - 1);
					expected_bytes.push_back(ob);
				end
				palettes_done++;
			end
			clear_sheet();
			return;
		end
		if (spilled)
			return;
		color = {bt.r, bt.g, bt.b, bt.a};
		found = 1'b0;
		idx   = 2'd0;
		for (int i = 0; i < pal_count; i++) begin
			if (!found && pal_colors[i] == color) begin
				found = 1'b1;
				idx   = 2'(i);
			end
		end
		if (!found) begin
			// a fifth color poisons the sheet
			if (pal_count >= PAL_ENTRIES) begin
				spilled = 1'b1;
				return;
			end
			idx = 2'(pal_count);
			pal_colors[pal_count] = color;
			pal_count++;
		end
		// column-major walk, rows stored bottom-up
		x   = tile_pos / TILE_ROWS;
		row = TILE_ROWS - 1 - (tile_pos % TILE_ROWS);
		lo_rows[row][x] = lo_rows[row][x] | idx[0];
		hi_rows[row][x] = hi_rows[row][x] | idx[1];
		if (tile_pos + 1 >= TILE_COLUMNS * TILE_ROWS) begin
			for (int k = 0; k < 16; k++) begin
				ob.data   = (k < 8) ? lo_rows[k] : hi_rows[k - 8];
				ob.kind   = KIND_PLANE;
				ob.status = STATUS_OK;
				ob.last   = (k == 15);
				expected_bytes.push_back(ob);
			end
			tiles_done++;
			clear_tile();
		end else begin
			tile_pos++;
		end
	endfunction

	task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic add_beat(logic op, logic [31:0] c);
		pixel_feed.push_back('{op, c[31:24], c[23:16], c[15:8], c[7:0]});
	endtask

	function automatic logic [31:0] fresh_color(ref logic [31:0] taken[$]);
		logic [31:0] c;
		bit clash;
		do begin
			case ($urandom_range(0, 9))
				0: c = 32'h0000_0000;
				1: c = 32'hFFFF_FFFF;
				default: c = $urandom;
			endcase
			clash = 1'b0;
			foreach (taken[i])
				if (taken[i] == c)
					clash = 1'b1;
		end while (clash);
		return c;
	endfunction

	// one sheet: four colors up front, then pixels drawn from them; some sheets spill a fifth color
	task automatic add_sheet(int room);
		logic [31:0] cols[$];
		logic [31:0] c;
		int n;
		int spill_at;
		bit spill;
		for (int k = 0; k < PAL_ENTRIES; k++)
			cols.push_back(fresh_color(cols));
		case ($urandom_range(0, 3))
			0: n = 64 * $urandom_range(1, 2);
			1: n = $urandom_range(4, 20);
			default: n = $urandom_range(21, 150);
		endcase
		// keep the whole run near its beat budget
		if (n > room - 1)
			n = room - 1;
		if (n < PAL_ENTRIES)
			n = PAL_ENTRIES;
		spill    = ($urandom_range(0, 2) == 0);
		spill_at = $urandom_range(PAL_ENTRIES, n);
		for (int k = 0; k < n; k++) begin
			if (k < PAL_ENTRIES)
				c = cols[k];
			else if (spill && k == spill_at)
				c = fresh_color(cols);
			else if (spill && k > spill_at && $urandom_range(0, 1) == 1)
				c = $urandom;
			else
				c = cols[$urandom_range(0, PAL_ENTRIES - 1)];
			add_beat(OP_PIXEL, c);
		end
		add_beat(OP_FINISH, $urandom);
	endtask

	// stimulus, reset and end of run
	initial begin
		clear_sheet();
		// clean sheet with a dropped partial tile, extreme channel values
		add_beat(OP_PIXEL, 32'h0000_0000);
		add_beat(OP_PIXEL, 32'hFFFF_FFFF);
		add_beat(OP_PIXEL, 32'hA5C3_3C5A);
		add_beat(OP_PIXEL, 32'h5A3C_C3A5);
		add_beat(OP_PIXEL, 32'hFFFF_FFFF);
		add_beat(OP_PIXEL, 32'h0000_0000);
		add_beat(OP_PIXEL, 32'h5A3C_C3A5);
		add_beat(OP_FINISH, 32'hFFFF_FFFF);
		// fifth color one bit off a known one, then ignored pixels, error finish
		add_beat(OP_PIXEL, 32'hA5C3_3C5A);
		add_beat(OP_PIXEL, 32'h5A3C_C3A5);
		add_beat(OP_PIXEL, 32'h0000_0000);
		add_beat(OP_PIXEL, 32'hFFFF_FFFF);
		add_beat(OP_PIXEL, 32'hFFFF_FFFE);
		add_beat(OP_PIXEL, 32'h0000_0000);
		add_beat(OP_PIXEL, 32'hFFFF_FFFE);
		add_beat(OP_FINISH, 32'h0000_0000);
		while (pixel_feed.size() < RANDOM_BEATS)
			add_sheet(RANDOM_BEATS - pixel_feed.size());

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (pixel_feed.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Run: %0d input beats, %0d full tiles, %0d palette dumps, %0d overflow finishes",
			beats_in, tiles_done, palettes_done, overflow_dumps);
		$display("Run: %0d output bytes checked, long output hold-off %0s",
			bytes_out, hold_done ? "done" : "not reached");
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// input side: predict on each accepted beat
	always @(posedge clk) begin
		if (in_beat) begin
			encode_beat('{opcode, red, green, blue, alpha});
			beats_in++;
		end
		in_taken <= in_beat;
	end

	// driver: present the next beat once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (feed_gap > 0) begin
				in_valid <= 1'b0;
				feed_gap <= feed_gap - 1;
			end else if (pixel_feed.size() != 0) begin
				next_beat = pixel_feed.pop_front();
				opcode   <= next_beat.op;
				red      <= next_beat.r;
				green    <= next_beat.g;
				blue     <= next_beat.b;
				alpha    <= next_beat.a;
				in_valid <= 1'b1;
				// keep pushing while the output is held off
				feed_gap <= (hold_left > 0) ? 0 : gap_length(in_burst);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && bytes_out >= 17) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					stall_left <= gap_length(out_burst);
			end
		end
	end

	// monitor: compare each output beat with the oldest expected byte
	always @(posedge clk) begin
		out_byte_t want;
		if (out_beat) begin
			bytes_out++;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte: expected none got data %h kind %b status %b last %b",
					$time, data_byte, kind, status, last);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				check_field("data_byte", want.data, data_byte);
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("status", 8'(want.status), 8'(status));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || in_beat || out_beat) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

endmodule
